### design/sand_grain_fall_step_assert.svh
// Assertion macros for the sand grain fall step block.
`ifndef SAND_GRAIN_FALL_STEP_ASSERT_SVH
`define SAND_GRAIN_FALL_STEP_ASSERT_SVH
`ifndef SYNTH
`define SGFS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgfs assertion failed");
`define SGFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgfs assertion failed");
`else
`define SGFS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define SGFS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### design/sgfs_pkg.sv
// Shared types and constants of the sand grain fall step block.
package sgfs_pkg;

	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CELL_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0]     GRID_RESET      = 6'd32;

	localparam logic [CELL_W-1:0] CELL_SHAPE = 3'b001;
	localparam logic [CELL_W-1:0] CELL_GRAIN = 3'b010;
	localparam logic [CELL_W-1:0] CELL_FELL  = 3'b100;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_FALL  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// fall candidates in the order they are tried
	localparam logic [2:0] CAND_DOWN     = 3'd0;
	localparam logic [2:0] CAND_DIAG_A   = 3'd1;
	localparam logic [2:0] CAND_DIAG_B   = 3'd2;
	localparam logic [2:0] CAND_SIDE_COL = 3'd3;
	localparam logic [2:0] CAND_SIDE_ROW = 3'd4;
	localparam logic [2:0] CAND_LAST     = CAND_SIDE_ROW;

	typedef enum logic [1:0] {
		WSEL_CLEAR,
		WSEL_ITEM,
		WSEL_SRC,
		WSEL_DST
	} wsel_t;

	typedef enum logic {
		RSEL_SRC,
		RSEL_CAND
	} rsel_t;

	typedef struct packed {
		logic  ld_item;
		logic  we;
		wsel_t wsel;
		rsel_t rsel;
		logic  k_inc;
		logic  clr_inc;
		logic  ld_src;
		logic  ld_dest;
		logic  ld_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       in_region;
		logic       cand_in_region;
		logic       cand_free;
		logic       k_last;
		logic       dest_is_src;
		logic       clr_last;
	} sts_t;

endpackage

### design/sand_grain_fall_step.sv
// Top level of the sand grain fall step block.
// Keeps a MAX_ROWS x MAX_COLS grid of 3-bit cells (shape, grain, fell) in one
// memory with one write port and a registered read. After reset the block sweeps
// the memory to zero, one cell a cycle, with in_stall high; config writes are
// taken during the sweep.
// One item is worked at a time, from accept to the next accept. A write or an
// out-of-region address goes straight to the result, a read first registers the
// source cell, and a fall then probes the five candidate cells in order, one
// memory read at a time (a candidate outside the region is skipped), followed by
// the source and destination write-back. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken.
`include "sand_grain_fall_step_assert.svh"
module sand_grain_fall_step #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sgfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgfs_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [4:0]                     row,
	input  logic [4:0]                     col,
	input  logic signed [1:0]              grav_x,
	input  logic signed [1:0]              grav_y,
	input  logic                           random_side,
	input  logic                           set_in_shape,
	input  logic                           set_grain,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [4:0]                     dest_row,
	output logic [4:0]                     dest_col,
	output logic                           moved,
	output logic                           grain,
	output logic                           in_shape,
	output logic                           fallen
);
	import sgfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sgfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sgfs_datapath #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.kind        (kind),
		.row         (row),
		.col         (col),
		.grav_x      (grav_x),
		.grav_y      (grav_y),
		.random_side (random_side),
		.set_in_shape(set_in_shape),
		.set_grain   (set_grain),
		.dest_row    (dest_row),
		.dest_col    (dest_col),
		.moved       (moved),
		.grain       (grain),
		.in_shape    (in_shape),
		.fallen      (fallen)
	);

	// a new result never overwrites one still waiting
	`SGFS_ASSERT_NOW(a_ld_out_has_room, clk, arst_n, cmd.ld_out, !out_valid || !out_stall)
	// once an item is taken the block is busy until its result is out
	`SGFS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// destination write-back only belongs to a fall inside the region
	`SGFS_ASSERT_NOW(a_dst_write_is_fall, clk, arst_n, cmd.we && (cmd.wsel == WSEL_DST),
		(sts.kind == KIND_FALL) && sts.in_region)

endmodule

### design/sgfs_ram.sv
// Generic single write port RAM with registered read.
module sgfs_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/sgfs_ctrl.sv
// Sequencer: memory sweep, source read, candidate probes, write-back, result hand-off.
module sgfs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  sgfs_pkg::sts_t sts,
	output sgfs_pkg::cmd_t cmd
);
	import sgfs_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SRC_RD,
		ST_SRC_CHK,
		ST_PROBE,
		ST_PCHK,
		ST_WR_SRC,
		ST_WR_DST,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.we      = 1'b1;
				cmd.wsel    = WSEL_CLEAR;
				cmd.clr_inc = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = ST_SRC_RD;
				end
			end
			ST_SRC_RD: begin
				cmd.rsel = RSEL_SRC;
				if (!sts.in_region) begin
					state_d = ST_DONE;
				end else if (sts.kind == KIND_WRITE) begin
					cmd.we   = 1'b1;
					cmd.wsel = WSEL_ITEM;
					state_d  = ST_DONE;
				end else begin
					state_d = ST_SRC_CHK;
				end
			end
			ST_SRC_CHK: begin
				cmd.ld_src = 1'b1;
				state_d    = (sts.kind == KIND_FALL) ? ST_PROBE : ST_DONE;
			end
			ST_PROBE: begin
				cmd.rsel = RSEL_CAND;
				if (sts.cand_in_region) begin
					state_d = ST_PCHK;
				end else if (sts.k_last) begin
					state_d = ST_WR_SRC;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			ST_PCHK: begin
				cmd.rsel = RSEL_CAND;
				if (sts.cand_free) begin
					cmd.ld_dest = 1'b1;
					state_d     = ST_WR_SRC;
				end else if (sts.k_last) begin
					state_d = ST_WR_SRC;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = ST_PROBE;
				end
			end
			ST_WR_SRC: begin
				// staying grain is handled by the destination write alone
				cmd.we   = !sts.dest_is_src;
				cmd.wsel = WSEL_SRC;
				state_d  = ST_WR_DST;
			end
			ST_WR_DST: begin
				cmd.we   = 1'b1;
				cmd.wsel = WSEL_DST;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/sgfs_datapath.sv
// Datapath: item and config registers, candidate cells, cell memory, result register.
module sgfs_datapath #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sgfs_pkg::cmd_t                      cmd,
	output sgfs_pkg::sts_t                      sts,
	input  logic                                cfg_we,
	input  logic [sgfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sgfs_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [1:0]                          kind,
	input  logic [4:0]                          row,
	input  logic [4:0]                          col,
	input  logic signed [1:0]                   grav_x,
	input  logic signed [1:0]                   grav_y,
	input  logic                                random_side,
	input  logic                                set_in_shape,
	input  logic                                set_grain,
	output logic [4:0]                          dest_row,
	output logic [4:0]                          dest_col,
	output logic                                moved,
	output logic                                grain,
	output logic                                in_shape,
	output logic                                fallen
);
	import sgfs_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [8:0] ROWS_CAP = 9'(MAX_ROWS);
	localparam logic [8:0] COLS_CAP = 9'(MAX_COLS);

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(MAX_COLS) + AW'(c);
	endfunction

	logic [CFG_W-1:0]  grid_width_q, grid_height_q;
	logic [8:0]        rows_lim, cols_lim;
	logic [1:0]        kind_q;
	logic [4:0]        row_q, col_q;
	logic signed [1:0] gx_q, gy_q;
	logic              side_q, set_shape_q, set_grain_q;
	logic [2:0]        k_q;
	logic [AW-1:0]     clr_addr_q;
	logic signed [7:0] r8, c8, x8, y8, s8, xs, ys, cr, cc;
	logic              src_in_region, cand_in_region, dest_is_src;
	logic [AW-1:0]     src_addr, cand_addr, raddr, waddr;
	logic [7:0]        dest_row_q, dest_col_q;
	logic [AW-1:0]     dest_addr_q;
	logic [CELL_W-1:0] src_q, dst_q, rdata, wdata, fin, item_val, res_val;
	logic              res_moved;
	logic [4:0]        res_row_q, res_col_q;
	logic              res_moved_q;
	logic [CELL_W-1:0] res_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_RESET;
			grid_height_q <= GRID_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
				REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
			endcase
		end
	end

	assign rows_lim = ({3'b000, grid_height_q} < ROWS_CAP) ? {3'b000, grid_height_q} : ROWS_CAP;
	assign cols_lim = ({3'b000, grid_width_q} < COLS_CAP) ? {3'b000, grid_width_q} : COLS_CAP;

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			kind_q      <= kind;
			row_q       <= row;
			col_q       <= col;
			gx_q        <= grav_x;
			gy_q        <= grav_y;
			side_q      <= random_side;
			set_shape_q <= set_in_shape;
			set_grain_q <= set_grain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= CAND_DOWN;
			clr_addr_q <= '0;
		end else begin
			if (cmd.ld_item) begin
				k_q <= CAND_DOWN;
			end else if (cmd.k_inc) begin
				k_q <= k_q + 3'd1;
			end
			if (cmd.clr_inc) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	assign src_in_region = ({4'b0000, row_q} < rows_lim) && ({4'b0000, col_q} < cols_lim);

	assign r8 = {3'b000, row_q};
	assign c8 = {3'b000, col_q};
	assign x8 = {{6{gx_q[1]}}, gx_q};
	assign y8 = {{6{gy_q[1]}}, gy_q};
	assign s8 = side_q ? 8'sd1 : -8'sd1;
	// x*s and y*s with s a unit step
	assign xs = side_q ? x8 : -x8;
	assign ys = side_q ? y8 : -y8;

	always_comb begin
		unique case (k_q)
			CAND_DOWN: begin
				cr = r8 + y8;
				cc = c8 + x8;
			end
			CAND_DIAG_A: begin
				cr = r8 + y8 + xs;
				cc = c8 + x8 + ys;
			end
			CAND_DIAG_B: begin
				cr = r8 + y8 - xs;
				cc = c8 + x8 - ys;
			end
			CAND_SIDE_COL: begin
				cr = r8;
				cc = c8 + s8;
			end
			CAND_SIDE_ROW: begin
				cr = r8 + s8;
				cc = c8;
			end
			default: begin
				cr = r8;
				cc = c8;
			end
		endcase
	end

	assign cand_in_region = !cr[7] && !cc[7] &&
		({1'b0, cr[7:0]} < rows_lim) && ({1'b0, cc[7:0]} < cols_lim);

	assign src_addr  = cell_addr(RW'(row_q), CW'(col_q));
	assign cand_addr = cell_addr(RW'(cr[7:0]), CW'(cc[7:0]));
	assign raddr     = (cmd.rsel == RSEL_CAND) ? cand_addr : src_addr;

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			dest_row_q  <= {3'b000, row};
			dest_col_q  <= {3'b000, col};
			dest_addr_q <= cell_addr(RW'(row), CW'(col));
		end else if (cmd.ld_dest) begin
			dest_row_q  <= cr[7:0];
			dest_col_q  <= cc[7:0];
			dest_addr_q <= cand_addr;
		end
		if (cmd.ld_src) begin
			src_q <= rdata;
		end
		if (cmd.ld_dest) begin
			dst_q <= rdata;
		end
	end

	assign dest_is_src = (dest_row_q == r8[7:0]) && (dest_col_q == c8[7:0]);
	assign item_val    = {1'b0, set_grain_q, set_shape_q};
	assign fin         = (dest_is_src ? src_q : dst_q) | CELL_GRAIN | CELL_FELL;

	always_comb begin
		unique case (cmd.wsel)
			WSEL_CLEAR: begin
				waddr = clr_addr_q;
				wdata = '0;
			end
			WSEL_ITEM: begin
				waddr = src_addr;
				wdata = item_val;
			end
			WSEL_SRC: begin
				waddr = src_addr;
				wdata = src_q & ~CELL_GRAIN;
			end
			WSEL_DST: begin
				waddr = dest_addr_q;
				wdata = fin;
			end
			default: begin
				waddr = clr_addr_q;
				wdata = '0;
			end
		endcase
	end

	sgfs_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		priority if (!src_in_region) begin
			res_val = '0;
		end else begin
			unique case (kind_q)
				KIND_WRITE: res_val = item_val;
				KIND_FALL:  res_val = fin;
				KIND_READ:  res_val = src_q;
				default:    res_val = src_q;
			endcase
		end
	end

	assign res_moved = src_in_region && (kind_q == KIND_FALL) && !dest_is_src;

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			res_row_q   <= dest_row_q[4:0];
			res_col_q   <= dest_col_q[4:0];
			res_moved_q <= res_moved;
			res_val_q   <= res_val;
		end
	end

	assign dest_row = res_row_q;
	assign dest_col = res_col_q;
	assign moved    = res_moved_q;
	assign grain    = |(res_val_q & CELL_GRAIN);
	assign in_shape = |(res_val_q & CELL_SHAPE);
	assign fallen   = |(res_val_q & CELL_FELL);

	assign sts.kind           = kind_q;
	assign sts.in_region      = src_in_region;
	assign sts.cand_in_region = cand_in_region;
	assign sts.cand_free      = (|(rdata & CELL_SHAPE)) && !(|(rdata & CELL_GRAIN));
	assign sts.k_last         = (k_q == CAND_LAST);
	assign sts.dest_is_src    = dest_is_src;
	assign sts.clr_last       = (clr_addr_q == AW'(DEPTH - 1));

endmodule

### tb/tb.sv
// Testbench for the sand grain fall step block: directed and random items against a grid model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sgfs_pkg::*;

	localparam int GRID_ROWS = 32;
	localparam int GRID_COLS = 32;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 20;
	localparam int ITEMS_PER_PHASE = 215;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [1:0]        kind;
		logic [4:0]        row;
		logic [4:0]        col;
		logic signed [1:0] grav_x;
		logic signed [1:0] grav_y;
		logic              side;
		logic              shape;
		logic              grain;
	} grain_item_t;

	typedef struct {
		logic [4:0] dest_row;
		logic [4:0] dest_col;
		logic       moved;
		logic       grain;
		logic       in_shape;
		logic       fallen;
	} cell_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           kind = '0;
	logic [4:0]           row = '0;
	logic [4:0]           col = '0;
	logic signed [1:0]    grav_x = '0;
	logic signed [1:0]    grav_y = '0;
	logic                 random_side = 1'b0;
	logic                 set_in_shape = 1'b0;
	logic                 set_grain = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [4:0]           dest_row;
	logic [4:0]           dest_col;
	logic                 moved;
	logic                 grain;
	logic                 in_shape;
	logic                 fallen;

	// grid model and its registers
	logic [CELL_W-1:0] grid_model [GRID_ROWS*GRID_COLS];
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	cell_result_t      cell_results_q [$];

	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int last_row = 0;
	int last_col = 0;

	int error_count = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int grains_moved = 0;
	int grid_settings = 0;

	sand_grain_fall_step u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.row         (row),
		.col         (col),
		.grav_x      (grav_x),
		.grav_y      (grav_y),
		.random_side (random_side),
		.set_in_shape(set_in_shape),
		.set_grain   (set_grain),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.dest_row    (dest_row),
		.dest_col    (dest_col),
		.moved       (moved),
		.grain       (grain),
		.in_shape    (in_shape),
		.fallen      (fallen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int rows_used();
		return (height_reg < GRID_ROWS) ? int'(height_reg) : GRID_ROWS;
	endfunction

	function automatic int cols_used();
		return (width_reg < GRID_COLS) ? int'(width_reg) : GRID_COLS;
	endfunction

	function automatic bit in_region(int r, int c);
		return r >= 0 && c >= 0 && r < rows_used() && c < cols_used();
	endfunction

	function automatic int cell_addr(int r, int c);
		return r * GRID_COLS + c;
	endfunction

	function automatic bit can_take(int r, int c);
		logic [CELL_W-1:0] v;
		if (!in_region(r, c))
			return 1'b0;
		v = grid_model[cell_addr(r, c)];
		return (v & CELL_SHAPE) != '0 && (v & CELL_GRAIN) == '0;
	endfunction

	// applies one item to the grid model and returns what the block should report
	function automatic cell_result_t predict_cell_result(grain_item_t it);
		int r, c, x, y, s, dr, dc, k;
		int cr [5];
		int cc [5];
		bit found;
		logic [CELL_W-1:0] v;
		cell_result_t res;
		r = it.row;
		c = it.col;
		x = int'(it.grav_x);
		y = int'(it.grav_y);
		s = it.side ? 1 : -1;
		dr = r;
		dc = c;
		v = '0;
		res.moved = 1'b0;
		if (in_region(r, c)) begin
			if (it.kind == KIND_WRITE) begin
				grid_model[cell_addr(r, c)] = (it.shape ? CELL_SHAPE : '0) |
					(it.grain ? CELL_GRAIN : '0);
			end else if (it.kind == KIND_FALL) begin
				cr[0] = r + y;         cc[0] = c + x;
				cr[1] = r + y + x * s; cc[1] = c + x + y * s;
				// second diagonal mirrors the first one
				cr[2] = r + y - x * s; cc[2] = c + x - y * s;
				cr[3] = r;             cc[3] = c + s;
				cr[4] = r + s;         cc[4] = c;
				found = 1'b0;
				for (k = 0; k < 5; k++) begin
					if (!found && can_take(cr[k], cc[k])) begin
						dr = cr[k];
						dc = cc[k];
						found = 1'b1;
					end
				end
				// destination gets a grain even when the source had none
				grid_model[cell_addr(r, c)] &= ~CELL_GRAIN;
				grid_model[cell_addr(dr, dc)] |= CELL_GRAIN | CELL_FELL;
				res.moved = (dr != r) || (dc != c);
				if (res.moved)
					grains_moved++;
			end
			v = grid_model[cell_addr(dr, dc)];
		end
		res.dest_row = dr[4:0];
		res.dest_col = dc[4:0];
		res.grain    = (v & CELL_GRAIN) != '0;
		res.in_shape = (v & CELL_SHAPE) != '0;
		res.fallen   = (v & CELL_FELL) != '0;
		return res;
	endfunction

	function automatic grain_item_t cell_op(logic [1:0] k, int r, int c, int gx, int gy,
			int side, int shape, int gr);
		grain_item_t it;
		it.kind   = k;
		it.row    = r[4:0];
		it.col    = c[4:0];
		it.grav_x = gx[1:0];
		it.grav_y = gy[1:0];
		it.side   = (side != 0);
		it.shape  = (shape != 0);
		it.grain  = (gr != 0);
		return it;
	endfunction

	function automatic int random_step();
		// mostly unit steps, now and then the out-of-range -2
		if ($urandom_range(9) == 0)
			return -2;
		return int'($urandom_range(2)) - 1;
	endfunction

	function automatic grain_item_t random_item();
		grain_item_t it;
		int pick, a, rows, cols, r, c, rr, cc, tries;
		bit found;
		rows = rows_used();
		cols = cols_used();
		pick = $urandom_range(99);
		if (pick < 35)
			it.kind = KIND_WRITE;
		else if (pick < 80)
			it.kind = KIND_FALL;
		else if (pick < 95)
			it.kind = KIND_READ;
		else
			it.kind = KIND_SPARE;
		a = $urandom_range(99);
		if (rows == 0 || cols == 0 || a < 12) begin
			r = $urandom_range(31);
			c = $urandom_range(31);
		end else if (a < 50) begin
			// stay near the last cell so grains pile up against each other
			r = (last_row + int'($urandom_range(4)) - 2 + rows) % rows;
			c = (last_col + int'($urandom_range(4)) - 2 + cols) % cols;
		end else begin
			r = $urandom_range(rows - 1);
			c = $urandom_range(cols - 1);
		end
		if (it.kind == KIND_FALL && rows > 0 && cols > 0 && $urandom_range(99) < 70) begin
			found = 1'b0;
			for (tries = 0; tries < 10; tries++) begin
				rr = $urandom_range(rows - 1);
				cc = $urandom_range(cols - 1);
				if (!found && (grid_model[cell_addr(rr, cc)] & CELL_GRAIN) != '0) begin
					r = rr;
					c = cc;
					found = 1'b1;
				end
			end
		end
		last_row = r;
		last_col = c;
		it.row    = r[4:0];
		it.col    = c[4:0];
		r = random_step();
		c = random_step();
		it.grav_x = r[1:0];
		it.grav_y = c[1:0];
		it.side   = ($urandom_range(1) != 0);
		it.shape  = $urandom_range(99) < 80;
		it.grain  = $urandom_range(99) < 35;
		return it;
	endfunction

	task automatic send_item(grain_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= it.kind;
		row          <= it.row;
		col          <= it.col;
		grav_x       <= it.grav_x;
		grav_y       <= it.grav_y;
		random_side  <= it.side;
		set_in_shape <= it.shape;
		set_grain    <= it.grain;
		do
			@(posedge clk);
		while (in_stall);
		cell_results_q.push_back(predict_cell_result(it));
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (cell_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg  = w;
		height_reg = h;
		grid_settings++;
	endtask

	task automatic test_cell_access();
		set_grid(6'd32, 6'd32);
		send_item(cell_op(KIND_WRITE, 0, 0, 0, 0, 0, 1, 1));
		send_item(cell_op(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
		send_item(cell_op(KIND_WRITE, 31, 31, 0, 0, 1, 1, 0));
		send_item(cell_op(KIND_SPARE, 31, 31, 1, 1, 1, 1, 1));
		send_item(cell_op(KIND_WRITE, 31, 0, 0, 0, 0, 0, 1));
		// bottom edge: every candidate is outside or off-shape
		send_item(cell_op(KIND_FALL, 31, 0, 0, 1, 1, 0, 0));
	endtask

	task automatic test_fall_order();
		wait_idle();
		// gravity down, side +1: candidates (11,10) (11,11) (11,9) (10,11) (11,10)
		send_item(cell_op(KIND_WRITE, 10, 10, 0, 0, 0, 1, 1));
		send_item(cell_op(KIND_FALL, 10, 10, 0, 1, 1, 0, 0));
		send_item(cell_op(KIND_WRITE, 10, 11, 0, 0, 0, 1, 0));
		send_item(cell_op(KIND_FALL, 10, 10, 0, 1, 1, 0, 0));
		send_item(cell_op(KIND_WRITE, 10, 10, 0, 0, 0, 1, 1));
		send_item(cell_op(KIND_WRITE, 11, 9, 0, 0, 0, 1, 0));
		send_item(cell_op(KIND_FALL, 10, 10, 0, 1, 1, 0, 0));
		send_item(cell_op(KIND_WRITE, 10, 10, 0, 0, 0, 1, 1));
		send_item(cell_op(KIND_WRITE, 11, 11, 0, 0, 0, 1, 0));
		send_item(cell_op(KIND_FALL, 10, 10, 0, 1, 1, 0, 0));
		send_item(cell_op(KIND_WRITE, 10, 10, 0, 0, 0, 1, 1));
		send_item(cell_op(KIND_WRITE, 11, 10, 0, 0, 0, 1, 0));
		send_item(cell_op(KIND_FALL, 10, 10, 0, 1, 1, 0, 0));
		// empty source with a double step lands on (10,10)
		send_item(cell_op(KIND_FALL, 12, 12, -2, -2, 0, 0, 0));
		// sideways gravity, side -1: only the row-side cell is free
		send_item(cell_op(KIND_WRITE, 20, 20, 0, 0, 0, 1, 1));
		send_item(cell_op(KIND_WRITE, 19, 20, 0, 0, 0, 1, 0));
		send_item(cell_op(KIND_FALL, 20, 20, 1, 0, 0, 0, 0));
	endtask

	task automatic test_region_limits();
		wait_idle();
		set_grid(6'd3, 6'd2);
		send_item(cell_op(KIND_WRITE, 1, 2, 0, 0, 0, 1, 0));
		send_item(cell_op(KIND_WRITE, 2, 0, 0, 0, 0, 1, 1));
		send_item(cell_op(KIND_FALL, 1, 2, 0, 1, 1, 0, 0));
		send_item(cell_op(KIND_READ, 0, 3, 0, 0, 0, 0, 0));
		wait_idle();
		set_grid(6'd0, 6'd0);
		send_item(cell_op(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
		send_item(cell_op(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();
		set_grid(6'd63, 6'd63);
		send_item(cell_op(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_mix(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int idle,
			int stall);
		wait_idle();
		set_grid(w, h);
		idle_pct = idle;
		stall_pct <= stall;
		repeat (ITEMS_PER_PHASE) send_item(random_item());
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		set_grid(6'd8, 6'd8);
		idle_pct = 0;
		stall_pct <= 0;
		hold_req <= ~hold_req;
		repeat (40) send_item(random_item());
	endtask

	task automatic check_cell_result();
		cell_result_t want;
		if (cell_results_q.size() == 0) begin
			error_count++;
			if (mismatch_count < REPORT_LIMIT)
				$display("unexpected result: row %0d col %0d", dest_row, dest_col);
			mismatch_count++;
		end else begin
			want = cell_results_q.pop_front();
			results_checked++;
			if (dest_row !== want.dest_row || dest_col !== want.dest_col ||
					moved !== want.moved || grain !== want.grain ||
					in_shape !== want.in_shape || fallen !== want.fallen) begin
				error_count++;
				if (mismatch_count < REPORT_LIMIT) begin
					$display("mismatch: expected row %0d col %0d moved %0b grain %0b %s",
						want.dest_row, want.dest_col, want.moved, want.grain,
						$sformatf("shape %0b fell %0b", want.in_shape, want.fallen));
					$display("          got row %0d col %0d moved %0b grain %0b %s",
						dest_row, dest_col, moved, grain,
						$sformatf("shape %0b fell %0b", in_shape, fallen));
				end
				mismatch_count++;
			end
		end
	endtask

	// result side: checks accepted items and drives out_stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_cell_result();
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
		out_stall <= (hold_req != hold_ack) || (hold_left > 1) ||
			($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < GRID_ROWS * GRID_COLS; i++)
			grid_model[i] = '0;
		width_reg  = GRID_RESET;
		height_reg = GRID_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_cell_access();
		test_fall_order();
		test_region_limits();
		test_random_mix(6'd8, 6'd8, 0, 0);
		test_random_mix(6'd32, 6'd32, 83, 0);
		test_random_mix(6'd5, 6'd3, 0, 83);
		test_random_mix(6'd16, 6'd16, 16, 16);
		test_random_mix(6'd63, 6'd63, 0, 0);
		test_random_mix(6'd1, 6'd32, 83, 0);
		test_random_mix(6'd32, 6'd1, 0, 83);
		test_random_mix(6'd12, 6'd7, 16, 16);
		test_output_backpressure();
		wait_idle();
		error_count += cell_results_q.size();

		$display("covered %0d items, %0d grid settings, %0d grain moves, %0d results checked",
			items_sent, grid_settings, grains_moved, results_checked);
		$display("handshake mixes: free flow, idle sender, stalling receiver, both, long hold-off");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### files.f
+incdir+design
design/sgfs_pkg.sv
design/sgfs_ram.sv
design/sgfs_ctrl.sv
design/sgfs_datapath.sv
design/sand_grain_fall_step.sv
tb/tb.sv
